### rtl/filtered_packet_ring_queue_macros.svh
// Assertion macros shared by the RTL. Every macro samples on clk and is
// disabled while arst_n is low.
`ifndef FILTERED_PACKET_RING_QUEUE_MACROS_SVH
`define FILTERED_PACKET_RING_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fpr_pkg.sv
package fpr_pkg;

	localparam int QUEUE_DEPTH  = 40;
	localparam int PACKET_BYTES = 14;
	localparam int STORE_DEPTH  = QUEUE_DEPTH * PACKET_BYTES;

	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int POS_W   = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ADDR_W-1:0]  PKT_STEP  = ADDR_W'(PACKET_BYTES);
	localparam logic [ADDR_W-1:0]  LAST_BASE = ADDR_W'(STORE_DEPTH - PACKET_BYTES);
	localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(PACKET_BYTES - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_DATA      = 3'd0,
		KIND_ACCEPTED  = 3'd1,
		KIND_DROP_ZERO = 3'd2,
		KIND_DROP_FULL = 3'd3,
		KIND_EMPTY     = 3'd4
	} kind_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  push_byte;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pop_byte;
		logic        last;
	} rsp_t;

endpackage

### rtl/fpr_ram.sv
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/filtered_packet_ring_queue.sv
// Ring queue of fixed-length packets held in one byte-wide synchronous RAM.
// Requests enter on req and are taken at a rising edge where start is high
// and busy is low. A push request carries one packet byte; bytes are written
// straight into the tail slot. The last byte of a packet produces one verdict
// result (accepted, dropped as all zero, or dropped because the queue was
// full at the first byte) in the cycle after the request is taken. Other push
// bytes produce no result and the block is ready again in the next cycle.
// A pop request on an empty queue, or while the sticky overflow flag is set,
// produces one empty result in the cycle after it is taken. Otherwise the head
// packet is streamed one byte per cycle, each byte passing through the RAM read
// register and then the result register; busy stays high until the last byte
// has been read, so no new request is taken while a packet streams, since the
// single RAM read port serves the stream. A clear request empties the queue
// and drops overflow and any partly staged packet, with no result.
// Results show on rsp for exactly one cycle, marked by strobe; the receiver
// cannot stall them. After reset the queue is empty and overflow is clear;
// the RAM contents are not cleared because only written slots are ever read.
module filtered_packet_ring_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fpr_pkg::req_t  req,
	output logic           busy,
	output logic           strobe,
	output fpr_pkg::rsp_t  rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t state_q;

	// Slots are tracked by their base byte address, which avoids a multiply.
	logic [fpr_pkg::ADDR_W-1:0]  head_base_q;
	logic [fpr_pkg::ADDR_W-1:0]  tail_base_q;
	logic [fpr_pkg::COUNT_W-1:0] count_q;
	logic                        overflow_q;
	logic [fpr_pkg::POS_W-1:0]   pos_q;
	logic                        nonzero_q;
	logic                        full_start_q;
	logic [fpr_pkg::POS_W-1:0]   idx_q;

	// Read pipeline: a read issued in one cycle returns data in the next.
	logic          rd_s1;
	logic          last_s1;

	logic          strobe_q;
	fpr_pkg::rsp_t rsp_q;

	logic                       accept;
	logic                       push_take;
	logic                       full_now;
	logic                       nonzero_now;
	logic                       ram_we;
	logic [fpr_pkg::ADDR_W-1:0] ram_waddr;
	logic [fpr_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]                 ram_rdata;
	logic                       data_rsp;
	logic                       pop_go;

	assign busy   = (state_q == ST_POP) || rd_s1;
	assign accept = start && !busy;
	assign push_take = accept && (req.opcode == fpr_pkg::OP_PUSH);

	// The fullness verdict is frozen at the first byte of each packet.
	assign full_now    = (pos_q == '0) ? (count_q >= fpr_pkg::COUNT_MAX) : full_start_q;
	assign nonzero_now = nonzero_q || (req.push_byte != 8'd0);

	assign ram_we    = push_take && !full_now;
	assign ram_waddr = tail_base_q + fpr_pkg::ADDR_W'(pos_q);
	assign ram_raddr = head_base_q + fpr_pkg::ADDR_W'(idx_q);

	fpr_ram #(
		.WIDTH(8),
		.DEPTH(fpr_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.push_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_base_q  <= '0;
			tail_base_q  <= '0;
			count_q      <= '0;
			overflow_q   <= 1'b0;
			pos_q        <= '0;
			nonzero_q    <= 1'b0;
			full_start_q <= 1'b0;
			idx_q        <= '0;
			rd_s1        <= 1'b0;
			last_s1      <= 1'b0;
			strobe_q     <= 1'b0;
			rsp_q        <= '0;
		end else begin
			strobe_q <= 1'b0;
			rd_s1    <= 1'b0;

			// Read data of the previous cycle is registered onto the result port.
			if (rd_s1) begin
				strobe_q <= 1'b1;
				rsp_q    <= '{kind: fpr_pkg::KIND_DATA, pop_byte: ram_rdata, last: last_s1};
			end

			case (state_q)
				ST_POP: begin
					rd_s1   <= 1'b1;
					last_s1 <= (idx_q == fpr_pkg::POS_LAST);
					idx_q   <= idx_q + 1'b1;
					if (idx_q == fpr_pkg::POS_LAST) begin
						state_q     <= ST_IDLE;
						head_base_q <= (head_base_q == fpr_pkg::LAST_BASE) ? '0 :
							head_base_q + fpr_pkg::PKT_STEP;
						count_q     <= count_q - fpr_pkg::COUNT_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req.opcode)
							fpr_pkg::OP_PUSH: begin
								if (pos_q == fpr_pkg::POS_LAST) begin
									strobe_q     <= 1'b1;
									pos_q        <= '0;
									nonzero_q    <= 1'b0;
									full_start_q <= 1'b0;
									if (full_now) begin
										overflow_q <= 1'b1;
										rsp_q <= '{kind: fpr_pkg::KIND_DROP_FULL,
											pop_byte: 8'd0, last: 1'b1};
									end else if (!nonzero_now) begin
										rsp_q <= '{kind: fpr_pkg::KIND_DROP_ZERO,
											pop_byte: 8'd0, last: 1'b1};
									end else begin
										tail_base_q <= (tail_base_q == fpr_pkg::LAST_BASE) ?
											'0 : tail_base_q + fpr_pkg::PKT_STEP;
										count_q     <= count_q + fpr_pkg::COUNT_W'(1);
										rsp_q <= '{kind: fpr_pkg::KIND_ACCEPTED,
											pop_byte: 8'd0, last: 1'b1};
									end
								end else begin
									pos_q        <= pos_q + 1'b1;
									nonzero_q    <= nonzero_now;
									full_start_q <= full_now;
								end
							end
							fpr_pkg::OP_POP: begin
								if ((count_q == '0) || overflow_q) begin
									strobe_q <= 1'b1;
									rsp_q    <= '{kind: fpr_pkg::KIND_EMPTY,
										pop_byte: 8'd0, last: 1'b1};
								end else begin
									state_q <= ST_POP;
									idx_q   <= '0;
								end
							end
							fpr_pkg::OP_CLEAR: begin
								head_base_q  <= '0;
								tail_base_q  <= '0;
								count_q      <= '0;
								overflow_q   <= 1'b0;
								pos_q        <= '0;
								nonzero_q    <= 1'b0;
								full_start_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// Conditions watched by the checks below.
	assign data_rsp = strobe_q && (rsp_q.kind == fpr_pkg::KIND_DATA);
	assign pop_go   = accept && (req.opcode == fpr_pkg::OP_POP) && (count_q != '0) &&
		!overflow_q;

`include "filtered_packet_ring_queue_macros.svh"

	// An empty queue always has its head and tail on the same slot.
	`FPR_ASSERT_SAME(a_empty_aligned, count_q == '0, head_base_q == tail_base_q, "pointers apart")

	// The count never goes past the number of slots.
	`FPR_ASSERT_SAME(a_count_bound, 1'b1, count_q <= fpr_pkg::COUNT_MAX, "count above depth")

	// A data byte on the result port always comes from a RAM read in the cycle before.
	`FPR_ASSERT_SAME(a_data_from_read, data_rsp, $past(rd_s1), "data result without a read")

	// A pop that starts streaming keeps the block busy in the next cycle.
	`FPR_ASSERT_NEXT(a_pop_busy, pop_go, busy, "pop stream not holding busy")

endmodule
